[rtl/core/vna_pkg.sv]
// Shared types and constants for the vertex normal averager.
// Holds payload structs, state encodings and datapath widths; no dependencies.
`timescale 1ns / 1ps

package vna_pkg;

  localparam int MAX_VERTICES = 1024;
  localparam int VIDX_W       = $clog2(MAX_VERTICES);
  localparam int COORD_W      = 32;
  localparam int NORM_W       = 16;
  localparam int EDGE_W       = COORD_W + 1;
  localparam int MUL_W        = 30;
  localparam int PROD_W       = 2 * MUL_W;
  localparam int ACC_W        = 63;
  localparam int MAG_W        = 61;
  localparam int SQ_W         = 62;
  localparam int ROOT_W       = 31;
  localparam int REM_W        = 33;
  localparam int QUO_W        = 15;
  localparam int FRAC_W       = 14;
  localparam int NUM_W        = MUL_W + FRAC_W + 1;
  localparam int CNT_W        = 5;
  localparam logic [QUO_W-1:0] UNIT_Q = QUO_W'(16384);

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_LOAD  = 2'd1,
    OP_FACE  = 2'd2,
    OP_READ  = 2'd3
  } op_t;

  typedef struct packed {
    op_t                       opcode;
    logic [VIDX_W-1:0]         vertex_id;
    logic signed [COORD_W-1:0] pos_x;
    logic signed [COORD_W-1:0] pos_y;
    logic signed [COORD_W-1:0] pos_z;
    logic [VIDX_W-1:0]         corner_a;
    logic [VIDX_W-1:0]         corner_b;
    logic [VIDX_W-1:0]         corner_c;
  } item_t;

  typedef struct packed {
    logic signed [NORM_W-1:0] normal_x;
    logic signed [NORM_W-1:0] normal_y;
    logic signed [NORM_W-1:0] normal_z;
    logic                     has_faces;
  } result_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
  } vec3_t;

  typedef struct packed {
    logic  touched;
    vec3_t sum;
  } sum_entry_t;

  typedef struct packed {
    logic signed [NORM_W-1:0] x;
    logic signed [NORM_W-1:0] y;
    logic signed [NORM_W-1:0] z;
  } norm3_t;

  typedef struct packed {
    logic start;
    logic face;
  } eng_req_t;

  typedef struct packed {
    logic done;
    logic nz;
  } eng_rsp_t;

  typedef enum logic [3:0] {
    T_SWEEP,
    T_IDLE,
    T_FACE_RD,
    T_ENG_GO,
    T_ENG_WAIT,
    T_ACC_RD,
    T_ACC_WR,
    T_READ_RD,
    T_READ_CAP,
    T_EMIT
  } top_state_t;

  typedef enum logic [3:0] {
    E_IDLE,
    E_EDGE,
    E_ESHIFT,
    E_XLOAD,
    E_XMUL,
    E_VLOAD,
    E_SCALE,
    E_SLOAD,
    E_SMUL,
    E_ROOT,
    E_DLOAD,
    E_DIV,
    E_DONE
  } eng_state_t;

endpackage

[rtl/core/vertex_normal_averager.sv]
// Smooth per-vertex normal accumulator for a triangle mesh (top level).
// Depends on vna_pkg, vna_ram and vna_engine.
// Usage:
//   item channel (item_valid / item_stall / item) carries one command: clear,
//   load position, add face or read normal. A transfer happens when
//   item_valid is high and item_stall low. Only read produces a result, on
//   the result channel (result_valid / result_stall / result), from an output
//   register; the next command is taken while that result waits.
//   cfg channel (cfg_valid / cfg_ready / cfg_data) writes reverse_winding;
//   cfg_ready is always high. Write it only while the block is idle.
// Operation:
//   clear zeroes one accumulator entry per cycle. add face runs in the
//   bit-serial engine: six 30-bit shift-add products for the cross product,
//   up to 31 scaling shifts, three squares, a 31-step root and three 15-step
//   divisions; a degenerate face skips the scaling, squares, root and
//   divisions. read runs the scaling, squares, root and divisions of the same
//   engine; an untouched or zero vertex skips them too.
// Reset: synchronous; the block then sweeps all 1024 accumulator entries,
//   with item_stall high, before the first transfer.
// A stalled result holds; a further read finishes its work and waits.
`timescale 1ns / 1ps

module vertex_normal_averager (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  output logic             item_stall,
  input  vna_pkg::item_t   item,
  output logic             result_valid,
  input  logic             result_stall,
  output vna_pkg::result_t result,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic             cfg_data
);

  vna_pkg::top_state_t state, state_next;

  logic                       reverse_winding;
  logic [1:0]                 cnt;
  logic [vna_pkg::VIDX_W-1:0] sweep_addr;
  vna_pkg::item_t             item_q;
  vna_pkg::vec3_t             pos_q [3];
  vna_pkg::vec3_t             sum_q;

  logic                       accept;
  logic                       out_free;
  logic [vna_pkg::VIDX_W-1:0] corner_sel;

  logic                       pos_we, pos_re;
  vna_pkg::vec3_t             pos_wdata, pos_rdata;
  logic                       sum_we, sum_re;
  logic [vna_pkg::VIDX_W-1:0] sum_waddr, sum_raddr;
  vna_pkg::sum_entry_t        sum_wdata, sum_rdata;
  vna_pkg::vec3_t             sum_base;

  vna_pkg::eng_req_t          eng_req;
  vna_pkg::eng_rsp_t          eng_rsp;
  vna_pkg::norm3_t            eng_nrm, face_n;

  function automatic logic signed [vna_pkg::COORD_W-1:0] sat_add(
    input logic signed [vna_pkg::COORD_W-1:0] a,
    input logic signed [vna_pkg::NORM_W-1:0]  b
  );
    logic signed [vna_pkg::COORD_W:0] s;
    s = {a[vna_pkg::COORD_W-1], a} + (vna_pkg::COORD_W + 1)'(b);
    if (s[vna_pkg::COORD_W] != s[vna_pkg::COORD_W-1]) begin
      return s[vna_pkg::COORD_W] ? {1'b1, {(vna_pkg::COORD_W-1){1'b0}}}
                                 : {1'b0, {(vna_pkg::COORD_W-1){1'b1}}};
    end
    return s[vna_pkg::COORD_W-1:0];
  endfunction

  vna_ram #(
    .WIDTH ($bits(vna_pkg::vec3_t)),
    .DEPTH (vna_pkg::MAX_VERTICES)
  ) u_pos_ram (
    .clk   (clk),
    .we    (pos_we),
    .waddr (item.vertex_id),
    .wdata (pos_wdata),
    .re    (pos_re),
    .raddr (corner_sel),
    .rdata (pos_rdata)
  );

  vna_ram #(
    .WIDTH ($bits(vna_pkg::sum_entry_t)),
    .DEPTH (vna_pkg::MAX_VERTICES)
  ) u_sum_ram (
    .clk   (clk),
    .we    (sum_we),
    .waddr (sum_waddr),
    .wdata (sum_wdata),
    .re    (sum_re),
    .raddr (sum_raddr),
    .rdata (sum_rdata)
  );

  vna_engine u_engine (
    .clk     (clk),
    .rst     (rst),
    .req     (eng_req),
    .pos_a   (pos_q[0]),
    .pos_b   (pos_q[1]),
    .pos_c   (pos_q[2]),
    .sum_vec (sum_q),
    .rsp     (eng_rsp),
    .nrm     (eng_nrm)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      vna_pkg::T_SWEEP:    if (sweep_addr == vna_pkg::VIDX_W'(vna_pkg::MAX_VERTICES - 1)) begin
                             state_next = vna_pkg::T_IDLE;
                           end
      vna_pkg::T_IDLE: begin
        if (accept) begin
          unique case (item.opcode)
            vna_pkg::OP_CLEAR: state_next = vna_pkg::T_SWEEP;
            vna_pkg::OP_LOAD:  state_next = vna_pkg::T_IDLE;
            vna_pkg::OP_FACE:  state_next = vna_pkg::T_FACE_RD;
            vna_pkg::OP_READ:  state_next = vna_pkg::T_READ_RD;
            default:           state_next = vna_pkg::T_IDLE;
          endcase
        end
      end
      vna_pkg::T_FACE_RD:  if (cnt == 2'd3) begin
                             state_next = vna_pkg::T_ENG_GO;
                           end
      vna_pkg::T_ENG_GO:   state_next = vna_pkg::T_ENG_WAIT;
      vna_pkg::T_ENG_WAIT: if (eng_rsp.done) begin
                             state_next = (item_q.opcode == vna_pkg::OP_FACE)
                                          ? vna_pkg::T_ACC_RD : vna_pkg::T_EMIT;
                           end
      vna_pkg::T_ACC_RD:   state_next = vna_pkg::T_ACC_WR;
      vna_pkg::T_ACC_WR:   state_next = (cnt == 2'd2) ? vna_pkg::T_IDLE : vna_pkg::T_ACC_RD;
      vna_pkg::T_READ_RD:  state_next = vna_pkg::T_READ_CAP;
      vna_pkg::T_READ_CAP: state_next = vna_pkg::T_ENG_GO;
      vna_pkg::T_EMIT:     if (out_free) begin
                             state_next = vna_pkg::T_IDLE;
                           end
      default:             state_next = vna_pkg::T_IDLE;
    endcase
  end

  always_comb begin
    item_stall = (state != vna_pkg::T_IDLE);
    cfg_ready  = 1'b1;
    accept     = item_valid && !item_stall;
    out_free   = !result_valid || !result_stall;

    unique case (cnt)
      2'd0:    corner_sel = item_q.corner_a;
      2'd1:    corner_sel = item_q.corner_b;
      default: corner_sel = item_q.corner_c;
    endcase

    pos_we      = accept && (item.opcode == vna_pkg::OP_LOAD);
    pos_wdata.x = item.pos_x;
    pos_wdata.y = item.pos_y;
    pos_wdata.z = item.pos_z;
    pos_re      = (state == vna_pkg::T_FACE_RD) && (cnt != 2'd3);

    face_n.x = reverse_winding ? -eng_nrm.x : eng_nrm.x;
    face_n.y = reverse_winding ? -eng_nrm.y : eng_nrm.y;
    face_n.z = reverse_winding ? -eng_nrm.z : eng_nrm.z;

    // an untouched entry counts as a zero accumulator
    sum_base = sum_rdata.touched ? sum_rdata.sum : '0;

    sum_re    = (state == vna_pkg::T_ACC_RD) || (state == vna_pkg::T_READ_RD);
    sum_raddr = (state == vna_pkg::T_READ_RD) ? item_q.vertex_id : corner_sel;
    sum_we    = (state == vna_pkg::T_SWEEP) || (state == vna_pkg::T_ACC_WR);
    sum_waddr = (state == vna_pkg::T_SWEEP) ? sweep_addr : corner_sel;
    if (state == vna_pkg::T_SWEEP) begin
      sum_wdata = '0;
    end else begin
      sum_wdata.touched = 1'b1;
      sum_wdata.sum.x   = sat_add(sum_base.x, face_n.x);
      sum_wdata.sum.y   = sat_add(sum_base.y, face_n.y);
      sum_wdata.sum.z   = sat_add(sum_base.z, face_n.z);
    end

    eng_req.start = (state == vna_pkg::T_ENG_GO);
    eng_req.face  = (item_q.opcode == vna_pkg::OP_FACE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= vna_pkg::T_SWEEP;
      sweep_addr      <= '0;
      reverse_winding <= 1'b0;
      result_valid    <= 1'b0;
      cnt             <= 2'd0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        reverse_winding <= cfg_data;
      end
      if (state == vna_pkg::T_SWEEP) begin
        sweep_addr <= sweep_addr + 1'b1;
      end
      if (accept) begin
        cnt <= 2'd0;
        if (item.opcode == vna_pkg::OP_CLEAR) begin
          sweep_addr <= '0;
        end
      end
      if ((state == vna_pkg::T_FACE_RD) || (state == vna_pkg::T_ACC_WR)) begin
        cnt <= cnt + 2'd1;
      end
      if (state == vna_pkg::T_ENG_WAIT) begin
        cnt <= 2'd0;
      end
      // drop the held result once transferred, load a fresh one when free
      if ((state == vna_pkg::T_EMIT) && out_free) begin
        result_valid <= 1'b1;
      end else if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_q <= item;
    end
    if ((state == vna_pkg::T_FACE_RD) && (cnt != 2'd0)) begin
      pos_q[2'(cnt - 2'd1)] <= pos_rdata;
    end
    if (state == vna_pkg::T_READ_CAP) begin
      sum_q <= sum_base;
    end
    if ((state == vna_pkg::T_EMIT) && out_free) begin
      result.normal_x  <= eng_nrm.x;
      result.normal_y  <= eng_nrm.y;
      result.normal_z  <= eng_nrm.z;
      result.has_faces <= eng_rsp.nz;
    end
  end

endmodule

[rtl/core/vna_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module vna_ram #(
  parameter int  WIDTH = 32,
  parameter int  DEPTH = 1024,
  localparam int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/core/vna_engine.sv]
// Bit-serial arithmetic engine: edge vectors, cross product, and Q1.14 normalisation.
// Depends on vna_pkg for widths, state encoding and request/response structs.
`timescale 1ns / 1ps

module vna_engine (
  input  logic              clk,
  input  logic              rst,
  input  vna_pkg::eng_req_t req,
  input  vna_pkg::vec3_t    pos_a,
  input  vna_pkg::vec3_t    pos_b,
  input  vna_pkg::vec3_t    pos_c,
  input  vna_pkg::vec3_t    sum_vec,
  output vna_pkg::eng_rsp_t rsp,
  output vna_pkg::norm3_t   nrm
);

  vna_pkg::eng_state_t state, state_next;

  logic                                face;
  logic [2:0]                          k;
  logic [vna_pkg::CNT_W-1:0]           bcnt;
  logic [vna_pkg::COORD_W-1:0]         emag [6];
  logic [5:0]                          eneg;
  logic [vna_pkg::PROD_W-1:0]          mcand;
  logic [vna_pkg::MUL_W-1:0]           mplier;
  logic                                mneg;
  logic signed [vna_pkg::ACC_W-1:0]    acc;
  logic signed [vna_pkg::ACC_W-1:0]    cr [3];
  logic [vna_pkg::MAG_W-1:0]           vmag [3];
  logic [2:0]                          vneg;
  logic [vna_pkg::SQ_W-1:0]            xsh;
  logic [vna_pkg::REM_W-1:0]           rem;
  logic [vna_pkg::ROOT_W-1:0]          root;
  logic [vna_pkg::ROOT_W-1:0]          dr;
  logic [vna_pkg::QUO_W-1:0]           nsh;
  logic [vna_pkg::QUO_W-1:0]           q;
  logic                                nz;
  logic signed [vna_pkg::NORM_W-1:0]   nv [3];

  // edge datapath
  logic signed [vna_pkg::COORD_W-1:0]  e_hi, e_lo;
  logic [vna_pkg::EDGE_W-1:0]          e_diff, e_negd;
  logic [vna_pkg::COORD_W-1:0]         e_mag;
  logic [vna_pkg::COORD_W-1:0]         eor;
  logic [1:0]                          eshift;
  // multiplier datapath
  logic [2:0]                          ia, ib;
  logic signed [vna_pkg::ACC_W-1:0]    addend, acc_sum;
  // normalisation datapath
  logic signed [vna_pkg::ACC_W-1:0]    src [3];
  logic signed [vna_pkg::ACC_W-1:0]    src_neg [3];
  logic                                src_nz;
  logic [vna_pkg::MAG_W-1:0]           vor;
  logic                                scale_down, scale_up;
  logic [vna_pkg::REM_W+1:0]           remx, trial, rem_diff;
  logic                                root_ge;
  logic [vna_pkg::NUM_W-1:0]           num;
  logic [vna_pkg::ROOT_W:0]            drx, drx_diff;
  logic                                d_ge;
  logic [vna_pkg::QUO_W-1:0]           q_fin, q_clamp;
  logic [vna_pkg::NORM_W-1:0]          q_ext, n_val;
  logic                                mul_last;

  always_comb begin
    unique case (k)
      3'd0:    begin e_hi = pos_b.x; e_lo = pos_a.x; end
      3'd1:    begin e_hi = pos_b.y; e_lo = pos_a.y; end
      3'd2:    begin e_hi = pos_b.z; e_lo = pos_a.z; end
      3'd3:    begin e_hi = pos_c.x; e_lo = pos_a.x; end
      3'd4:    begin e_hi = pos_c.y; e_lo = pos_a.y; end
      default: begin e_hi = pos_c.z; e_lo = pos_a.z; end
    endcase
    e_diff = {e_hi[vna_pkg::COORD_W-1], e_hi} - {e_lo[vna_pkg::COORD_W-1], e_lo};
    e_negd = -e_diff;
    e_mag  = e_diff[vna_pkg::EDGE_W-1] ? e_negd[vna_pkg::COORD_W-1:0]
                                       : e_diff[vna_pkg::COORD_W-1:0];

    eor = emag[0] | emag[1] | emag[2] | emag[3] | emag[4] | emag[5];
    priority if (eor[vna_pkg::COORD_W-1]) begin
      eshift = 2'd2;
    end else if (eor[vna_pkg::COORD_W-2]) begin
      eshift = 2'd1;
    end else begin
      eshift = 2'd0;
    end

    // cross terms: even k adds, odd k subtracts
    unique case (k)
      3'd0:    begin ia = 3'd1; ib = 3'd5; end
      3'd1:    begin ia = 3'd2; ib = 3'd4; end
      3'd2:    begin ia = 3'd2; ib = 3'd3; end
      3'd3:    begin ia = 3'd0; ib = 3'd5; end
      3'd4:    begin ia = 3'd0; ib = 3'd4; end
      default: begin ia = 3'd1; ib = 3'd3; end
    endcase

    addend  = vna_pkg::ACC_W'(mcand);
    acc_sum = acc;
    if (mplier[0]) begin
      acc_sum = mneg ? acc - addend : acc + addend;
    end
    mul_last = (bcnt == vna_pkg::CNT_W'(vna_pkg::MUL_W - 1));

    src[0] = face ? cr[0] : vna_pkg::ACC_W'(sum_vec.x);
    src[1] = face ? cr[1] : vna_pkg::ACC_W'(sum_vec.y);
    src[2] = face ? cr[2] : vna_pkg::ACC_W'(sum_vec.z);
    for (int i = 0; i < 3; i++) begin
      src_neg[i] = -src[i];
    end
    src_nz = (src[0] != '0) || (src[1] != '0) || (src[2] != '0);

    vor        = vmag[0] | vmag[1] | vmag[2];
    scale_down = |vor[vna_pkg::MAG_W-1:vna_pkg::MUL_W];
    scale_up   = !vor[vna_pkg::MUL_W-1];

    remx     = {rem, xsh[vna_pkg::SQ_W-1 -: 2]};
    trial    = {2'b00, root, 2'b01};
    root_ge  = (remx >= trial);
    rem_diff = remx - trial;

    num = {1'b0, vmag[k[1:0]][vna_pkg::MUL_W-1:0], vna_pkg::FRAC_W'(0)}
          + vna_pkg::NUM_W'(root[vna_pkg::ROOT_W-1:1]);

    drx      = {dr, nsh[vna_pkg::QUO_W-1]};
    d_ge     = (drx >= {1'b0, root});
    drx_diff = drx - {1'b0, root};
    q_fin    = {q[vna_pkg::QUO_W-2:0], d_ge};
    q_clamp  = (q_fin > vna_pkg::UNIT_Q) ? vna_pkg::UNIT_Q : q_fin;
    q_ext    = {1'b0, q_clamp};
    n_val    = vneg[k[1:0]] ? -q_ext : q_ext;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      vna_pkg::E_IDLE:   if (req.start) begin
                           state_next = req.face ? vna_pkg::E_EDGE : vna_pkg::E_VLOAD;
                         end
      vna_pkg::E_EDGE:   if (k == 3'd5) begin
                           state_next = vna_pkg::E_ESHIFT;
                         end
      vna_pkg::E_ESHIFT: state_next = vna_pkg::E_XLOAD;
      vna_pkg::E_XLOAD:  state_next = vna_pkg::E_XMUL;
      vna_pkg::E_XMUL:   if (mul_last) begin
                           state_next = (k == 3'd5) ? vna_pkg::E_VLOAD : vna_pkg::E_XLOAD;
                         end
      vna_pkg::E_VLOAD:  state_next = src_nz ? vna_pkg::E_SCALE : vna_pkg::E_DONE;
      vna_pkg::E_SCALE:  if (!scale_down && !scale_up) begin
                           state_next = vna_pkg::E_SLOAD;
                         end
      vna_pkg::E_SLOAD:  state_next = vna_pkg::E_SMUL;
      vna_pkg::E_SMUL:   if (mul_last) begin
                           state_next = (k == 3'd2) ? vna_pkg::E_ROOT : vna_pkg::E_SLOAD;
                         end
      vna_pkg::E_ROOT:   if (bcnt == vna_pkg::CNT_W'(vna_pkg::ROOT_W - 1)) begin
                           state_next = vna_pkg::E_DLOAD;
                         end
      vna_pkg::E_DLOAD:  state_next = vna_pkg::E_DIV;
      vna_pkg::E_DIV:    if (bcnt == vna_pkg::CNT_W'(vna_pkg::QUO_W - 1)) begin
                           state_next = (k == 3'd2) ? vna_pkg::E_DONE : vna_pkg::E_DLOAD;
                         end
      vna_pkg::E_DONE:   state_next = vna_pkg::E_IDLE;
      default:           state_next = vna_pkg::E_IDLE;
    endcase
  end

  always_comb begin
    rsp.done = (state == vna_pkg::E_DONE);
    rsp.nz   = nz;
    nrm.x    = nv[0];
    nrm.y    = nv[1];
    nrm.z    = nv[2];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= vna_pkg::E_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      vna_pkg::E_IDLE: begin
        if (req.start) begin
          face <= req.face;
          k    <= 3'd0;
        end
      end
      vna_pkg::E_EDGE: begin
        emag[k] <= e_mag;
        eneg[k] <= e_diff[vna_pkg::EDGE_W-1];
        k       <= (k == 3'd5) ? 3'd0 : k + 3'd1;
      end
      vna_pkg::E_ESHIFT: begin
        for (int i = 0; i < 6; i++) begin
          emag[i] <= emag[i] >> eshift;
        end
        k <= 3'd0;
      end
      vna_pkg::E_XLOAD: begin
        mcand  <= vna_pkg::PROD_W'(emag[ia][vna_pkg::MUL_W-1:0]);
        mplier <= emag[ib][vna_pkg::MUL_W-1:0];
        mneg   <= eneg[ia] ^ eneg[ib] ^ k[0];
        bcnt   <= '0;
        if (!k[0]) begin
          acc <= '0;
        end
      end
      vna_pkg::E_XMUL: begin
        acc    <= acc_sum;
        mcand  <= mcand << 1;
        mplier <= mplier >> 1;
        bcnt   <= bcnt + 1'b1;
        if (mul_last) begin
          if (k[0]) begin
            cr[k[2:1]] <= acc_sum;
          end
          k <= k + 3'd1;
        end
      end
      vna_pkg::E_VLOAD: begin
        for (int i = 0; i < 3; i++) begin
          vneg[i] <= src[i][vna_pkg::ACC_W-1];
          vmag[i] <= src[i][vna_pkg::ACC_W-1] ? src_neg[i][vna_pkg::MAG_W-1:0]
                                              : src[i][vna_pkg::MAG_W-1:0];
          if (!src_nz) begin
            nv[i] <= '0;
          end
        end
        nz <= src_nz;
      end
      vna_pkg::E_SCALE: begin
        // bring the largest magnitude into [2^29, 2^30), one bit a cycle
        priority if (scale_down) begin
          for (int i = 0; i < 3; i++) begin
            vmag[i] <= vmag[i] >> 1;
          end
        end else if (scale_up) begin
          for (int i = 0; i < 3; i++) begin
            vmag[i] <= vmag[i] << 1;
          end
        end else begin
          acc <= '0;
          k   <= 3'd0;
        end
      end
      vna_pkg::E_SLOAD: begin
        mcand  <= vna_pkg::PROD_W'(vmag[k[1:0]][vna_pkg::MUL_W-1:0]);
        mplier <= vmag[k[1:0]][vna_pkg::MUL_W-1:0];
        mneg   <= 1'b0;
        bcnt   <= '0;
      end
      vna_pkg::E_SMUL: begin
        acc    <= acc_sum;
        mcand  <= mcand << 1;
        mplier <= mplier >> 1;
        bcnt   <= bcnt + 1'b1;
        if (mul_last) begin
          if (k == 3'd2) begin
            xsh  <= acc_sum[vna_pkg::SQ_W-1:0];
            rem  <= '0;
            root <= '0;
            bcnt <= '0;
            k    <= 3'd0;
          end else begin
            k <= k + 3'd1;
          end
        end
      end
      vna_pkg::E_ROOT: begin
        rem  <= root_ge ? rem_diff[vna_pkg::REM_W-1:0] : remx[vna_pkg::REM_W-1:0];
        root <= {root[vna_pkg::ROOT_W-2:0], root_ge};
        xsh  <= xsh << 2;
        bcnt <= bcnt + 1'b1;
      end
      vna_pkg::E_DLOAD: begin
        dr   <= {1'b0, num[vna_pkg::NUM_W-1:vna_pkg::QUO_W]};
        nsh  <= num[vna_pkg::QUO_W-1:0];
        q    <= '0;
        bcnt <= '0;
      end
      vna_pkg::E_DIV: begin
        dr   <= d_ge ? drx_diff[vna_pkg::ROOT_W-1:0] : drx[vna_pkg::ROOT_W-1:0];
        nsh  <= nsh << 1;
        q    <= q_fin;
        bcnt <= bcnt + 1'b1;
        if (bcnt == vna_pkg::CNT_W'(vna_pkg::QUO_W - 1)) begin
          nv[k[1:0]] <= n_val;
          k          <= k + 3'd1;
        end
      end
      vna_pkg::E_DONE: begin
      end
      default: begin
      end
    endcase
  end

endmodule

[rtl/core/vna_checker.sv]
// Port-level checks for the vertex normal averager, attached by bind.
// Depends on vna_pkg for the payload structs.
`timescale 1ns / 1ps

module vna_checker (
  input logic             clk,
  input logic             rst,
  input logic             item_stall,
  input logic             result_valid,
  input logic             result_stall,
  input vna_pkg::result_t result
);

  // hold a stalled result
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result))
    else $error("stalled result changed or dropped");

  a_reset_sweep: assert property (@(posedge clk)
    rst |=> item_stall && !result_valid)
    else $error("block not stalled and empty after reset");

  a_no_faces_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.has_faces |->
      result.normal_x == '0 && result.normal_y == '0 && result.normal_z == '0)
    else $error("vertex without faces returned a nonzero normal");

  a_unit_range: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.has_faces |->
      (result.normal_x <= 16'sd16384 && result.normal_x >= -16'sd16384 &&
       result.normal_y <= 16'sd16384 && result.normal_y >= -16'sd16384 &&
       result.normal_z <= 16'sd16384 && result.normal_z >= -16'sd16384) &&
      (result.normal_x != '0 || result.normal_y != '0 || result.normal_z != '0))
    else $error("normal outside unit range or zero with faces");

endmodule

bind vertex_normal_averager vna_checker u_vna_checker (
  .clk          (clk),
  .rst          (rst),
  .item_stall   (item_stall),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .result       (result)
);
